/* rtl/bmlc_pkg.sv */
// Shared widths, register indexes and types of the bounding-box motion liveness check.
package bmlc_pkg;

  localparam int COORD_BITS     = 13;
  localparam int SIZE_BITS      = COORD_BITS - 1;
  localparam int CENTRE_BITS    = COORD_BITS + 2;
  localparam int DIFF_BITS      = CENTRE_BITS + 1;
  localparam int ABS_BITS       = CENTRE_BITS;
  localparam int SQ_BITS        = 2 * ABS_BITS;
  localparam int SUM_BITS       = SQ_BITS + 1;
  localparam int DIST_BITS      = SUM_BITS + 6;

  localparam int BOUND_BITS     = 16;
  localparam int BOUND_SQ_BITS  = 2 * BOUND_BITS;
  localparam int CMP_BITS       = (DIST_BITS > BOUND_SQ_BITS) ? DIST_BITS : BOUND_SQ_BITS;

  localparam int IN_DATA_BITS   = 2 * COORD_BITS + 2 * SIZE_BITS;
  localparam int IN_TDATA_BITS  = ((IN_DATA_BITS + 7) / 8) * 8;
  localparam int OUT_TDATA_BITS = 8;

  localparam int CFG_IDX_BITS   = 1;
  localparam logic [CFG_IDX_BITS-1:0] CFG_MIN_SHIFT = 1'd0;
  localparam logic [CFG_IDX_BITS-1:0] CFG_MAX_SHIFT = 1'd1;

  localparam logic [BOUND_BITS-1:0] MIN_SHIFT_RESET = 16'd32;
  localparam logic [BOUND_BITS-1:0] MAX_SHIFT_RESET = 16'd1600;

  typedef struct packed {
    logic moved;
    logic jumped;
  } step_flags_t;

endpackage

/* rtl/bmlc_cfg_regs.sv */
// Bound registers, held squared so that the per-box test needs no further multiply.
module bmlc_cfg_regs
  import bmlc_pkg::*;
(
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     cfg_we,
  input  logic [CFG_IDX_BITS-1:0]  cfg_index,
  input  logic [BOUND_BITS-1:0]    cfg_data,
  output logic [BOUND_SQ_BITS-1:0] min_sq,
  output logic [BOUND_SQ_BITS-1:0] max_sq
);

  localparam logic [BOUND_SQ_BITS-1:0] MIN_SQ_RESET =
    BOUND_SQ_BITS'(MIN_SHIFT_RESET) * BOUND_SQ_BITS'(MIN_SHIFT_RESET);
  localparam logic [BOUND_SQ_BITS-1:0] MAX_SQ_RESET =
    BOUND_SQ_BITS'(MAX_SHIFT_RESET) * BOUND_SQ_BITS'(MAX_SHIFT_RESET);

  logic [BOUND_SQ_BITS-1:0] data_sq;
  logic [BOUND_SQ_BITS-1:0] min_sq_r, min_sq_nxt;
  logic [BOUND_SQ_BITS-1:0] max_sq_r, max_sq_nxt;

  assign data_sq = BOUND_SQ_BITS'(cfg_data) * BOUND_SQ_BITS'(cfg_data);

  always_comb begin
    min_sq_nxt = min_sq_r;
    max_sq_nxt = max_sq_r;
    if (cfg_we) begin
      case (cfg_index)
        CFG_MIN_SHIFT: min_sq_nxt = data_sq;
        CFG_MAX_SHIFT: max_sq_nxt = data_sq;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      min_sq_r <= MIN_SQ_RESET;
      max_sq_r <= MAX_SQ_RESET;
    end else begin
      min_sq_r <= min_sq_nxt;
      max_sq_r <= max_sq_nxt;
    end
  end

  assign min_sq = min_sq_r;
  assign max_sq = max_sq_r;

endmodule

/* rtl/bmlc_shift_calc.sv */
// Doubled box centre and squared centre shift tested against the squared bounds.
module bmlc_shift_calc
  import bmlc_pkg::*;
(
  input  logic [COORD_BITS-1:0]    box_left,
  input  logic [COORD_BITS-1:0]    box_top,
  input  logic [SIZE_BITS-1:0]     box_width,
  input  logic [SIZE_BITS-1:0]     box_height,
  input  logic [CENTRE_BITS-1:0]   prev_x2,
  input  logic [CENTRE_BITS-1:0]   prev_y2,
  input  logic [BOUND_SQ_BITS-1:0] min_sq,
  input  logic [BOUND_SQ_BITS-1:0] max_sq,
  output logic [CENTRE_BITS-1:0]   centre_x2,
  output logic [CENTRE_BITS-1:0]   centre_y2,
  output step_flags_t              flags
);

  logic [DIFF_BITS-1:0] dx, dy, dx_abs, dy_abs;
  logic [SQ_BITS-1:0]   sq_x, sq_y;
  logic [SUM_BITS-1:0]  sum_sq;
  logic [CMP_BITS-1:0]  shift_sq, min_cmp, max_cmp;

  assign centre_x2 = {box_left[COORD_BITS-1], box_left, 1'b0}
                   + {{(CENTRE_BITS-SIZE_BITS){1'b0}}, box_width};
  assign centre_y2 = {box_top[COORD_BITS-1], box_top, 1'b0}
                   + {{(CENTRE_BITS-SIZE_BITS){1'b0}}, box_height};

  assign dx = {centre_x2[CENTRE_BITS-1], centre_x2} - {prev_x2[CENTRE_BITS-1], prev_x2};
  assign dy = {centre_y2[CENTRE_BITS-1], centre_y2} - {prev_y2[CENTRE_BITS-1], prev_y2};

  assign dx_abs = dx[DIFF_BITS-1] ? (~dx + 1'b1) : dx;
  assign dy_abs = dy[DIFF_BITS-1] ? (~dy + 1'b1) : dy;

  assign sq_x = dx_abs[ABS_BITS-1:0] * dx_abs[ABS_BITS-1:0];
  assign sq_y = dy_abs[ABS_BITS-1:0] * dy_abs[ABS_BITS-1:0];

  assign sum_sq   = {1'b0, sq_x} + {1'b0, sq_y};
  assign shift_sq = CMP_BITS'({sum_sq, 6'b0});
  assign min_cmp  = CMP_BITS'(min_sq);
  assign max_cmp  = CMP_BITS'(max_sq);

  assign flags.moved  = (shift_sq >= min_cmp);
  assign flags.jumped = (shift_sq > max_cmp);

endmodule

/* rtl/bbox_motion_liveness_check.sv */
// Top level of the bounding-box motion liveness check.
// Takes one face box per transaction and gives one verdict on the box that carries
// in_tlast. Each box is registered, its centre shift is squared and tested against the bounds
// in one pass, and the verdict lands in an output register. A box can be accepted every
// cycle; the input stalls only while a last box waits behind a verdict that has not been
// taken. out_tvalid rises once an accepted last box has passed the input register and its
// verdict sits in the output register. Bound writes take effect in the next cycle.
module bbox_motion_liveness_check
  import bmlc_pkg::*;
(
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_tvalid,
  output logic                      in_tready,
  // box_left, box_top, box_width, box_height, zero padding
  input  logic [IN_TDATA_BITS-1:0]  in_tdata,
  input  logic                      in_tlast,
  output logic                      out_tvalid,
  input  logic                      out_tready,
  // live, boxes_seen, zero padding
  output logic [OUT_TDATA_BITS-1:0] out_tdata,
  input  logic                      cfg_we,
  input  logic [CFG_IDX_BITS-1:0]   cfg_index,
  input  logic [BOUND_BITS-1:0]     cfg_data
);

  localparam int TOP_LSB    = COORD_BITS;
  localparam int WIDTH_LSB  = 2 * COORD_BITS;
  localparam int HEIGHT_LSB = 2 * COORD_BITS + SIZE_BITS;

  logic [BOUND_SQ_BITS-1:0] min_sq, max_sq;
  logic [CENTRE_BITS-1:0]   centre_x2, centre_y2;
  step_flags_t              flags;

  logic                     s1_valid_r, s1_valid_nxt;
  logic                     s1_last_r;
  logic [IN_DATA_BITS-1:0]  s1_data_r;
  logic                     s1_fire;

  logic [CENTRE_BITS-1:0]   prev_x2_r, prev_x2_nxt;
  logic [CENTRE_BITS-1:0]   prev_y2_r, prev_y2_nxt;
  logic                     have_prev_r, have_prev_nxt;
  logic                     moved_r, moved_nxt;
  logic                     jumped_r, jumped_nxt;

  logic                     out_valid_r, out_valid_nxt;
  logic                     live_r, live_nxt;
  logic                     seen_r, seen_nxt;

  logic                     moved_acc, jumped_acc;

  bmlc_cfg_regs u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .min_sq    (min_sq),
    .max_sq    (max_sq)
  );

  bmlc_shift_calc u_calc (
    .box_left   (s1_data_r[COORD_BITS-1:0]),
    .box_top    (s1_data_r[TOP_LSB +: COORD_BITS]),
    .box_width  (s1_data_r[WIDTH_LSB +: SIZE_BITS]),
    .box_height (s1_data_r[HEIGHT_LSB +: SIZE_BITS]),
    .prev_x2    (prev_x2_r),
    .prev_y2    (prev_y2_r),
    .min_sq     (min_sq),
    .max_sq     (max_sq),
    .centre_x2  (centre_x2),
    .centre_y2  (centre_y2),
    .flags      (flags)
  );

  assign s1_fire   = s1_valid_r && (!s1_last_r || !out_valid_r || out_tready);
  assign in_tready = !s1_valid_r || s1_fire;

  assign moved_acc  = moved_r  || (have_prev_r && flags.moved);
  assign jumped_acc = jumped_r || (have_prev_r && flags.jumped);

  always_comb begin
    s1_valid_nxt  = s1_valid_r;
    prev_x2_nxt   = prev_x2_r;
    prev_y2_nxt   = prev_y2_r;
    have_prev_nxt = have_prev_r;
    moved_nxt     = moved_r;
    jumped_nxt    = jumped_r;
    out_valid_nxt = out_valid_r && !out_tready;
    live_nxt      = live_r;
    seen_nxt      = seen_r;

    if (in_tready) begin
      s1_valid_nxt = in_tvalid;
    end

    if (s1_fire) begin
      if (s1_last_r) begin
        // emit the verdict and clear the sequence
        out_valid_nxt = 1'b1;
        live_nxt      = have_prev_r && moved_acc && !jumped_acc;
        seen_nxt      = have_prev_r;
        prev_x2_nxt   = '0;
        prev_y2_nxt   = '0;
        have_prev_nxt = 1'b0;
        moved_nxt     = 1'b0;
        jumped_nxt    = 1'b0;
      end else begin
        prev_x2_nxt   = centre_x2;
        prev_y2_nxt   = centre_y2;
        have_prev_nxt = 1'b1;
        moved_nxt     = moved_acc;
        jumped_nxt    = jumped_acc;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      prev_x2_r   <= '0;
      prev_y2_r   <= '0;
      have_prev_r <= 1'b0;
      moved_r     <= 1'b0;
      jumped_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      prev_x2_r   <= prev_x2_nxt;
      prev_y2_r   <= prev_y2_nxt;
      have_prev_r <= have_prev_nxt;
      moved_r     <= moved_nxt;
      jumped_r    <= jumped_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) begin
      s1_data_r <= in_tdata[IN_DATA_BITS-1:0];
      s1_last_r <= in_tlast;
    end
    live_r <= live_nxt;
    seen_r <= seen_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {{(OUT_TDATA_BITS-2){1'b0}}, seen_r, live_r};

  a_live_needs_pair: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (!live_r || seen_r))
    else $error("live verdict without a pair of boxes");

  a_clear_after_last: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_fire && s1_last_r) |=> (!have_prev_r && !moved_r && !jumped_r))
    else $error("sequence state not cleared after last box");

  a_no_verdict_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_fire && s1_last_r) |-> !(out_valid_r && !out_tready))
    else $error("verdict overwritten while stalled");

  a_stall_only_when_full: assert property (@(posedge clk) disable iff (!rst_n)
    !in_tready |-> (s1_valid_r && s1_last_r && out_valid_r))
    else $error("input stalled without a pending verdict");

endmodule

/* tb/sv/tb_bbox_motion_liveness_check.sv */
// Self-checking bench for the bounding-box motion liveness check: table, then random runs.
module tb_bbox_motion_liveness_check;
  import bmlc_pkg::*;

  typedef enum logic {ROW_BOX, ROW_BOUND} row_kind_t;

  typedef struct {
    logic signed [COORD_BITS-1:0] left;
    logic signed [COORD_BITS-1:0] top;
    logic [SIZE_BITS-1:0]         width;
    logic [SIZE_BITS-1:0]         height;
    logic                         last;
  } box_t;

  typedef struct {
    logic live;
    logic boxes_seen;
  } verdict_t;

  typedef struct {
    row_kind_t               kind;
    logic [CFG_IDX_BITS-1:0] idx;
    logic [BOUND_BITS-1:0]   value;
    box_t                    box;
    bit                      typed;
    verdict_t                want;
  } stim_row_t;

  logic                      clk;
  logic                      rst_n;
  logic                      in_tvalid;
  logic                      in_tready;
  logic [IN_TDATA_BITS-1:0]  in_tdata;
  logic                      in_tlast;
  logic                      out_tvalid;
  logic                      out_tready;
  logic [OUT_TDATA_BITS-1:0] out_tdata;
  logic                      cfg_we;
  logic [CFG_IDX_BITS-1:0]   cfg_index;
  logic [BOUND_BITS-1:0]     cfg_data;

  logic [BOUND_BITS-1:0] min_bound;
  logic [BOUND_BITS-1:0] max_bound;
  longint                prev_cx2;
  longint                prev_cy2;
  bit                    have_prev;
  bit                    moved;
  bit                    jumped;

  verdict_t pending_verdicts[$];
  verdict_t head_verdict;
  int       mismatch_count;
  int       rx_hold;
  int       rx_roll;
  bit       rx_calm;
  bit       tx_calm;

  bbox_motion_liveness_check u_top (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #6_000_000;
    $display("CHECK FAILED");
    $finish;
  end

  function automatic void clear_track();
    prev_cx2  = 0;
    prev_cy2  = 0;
    have_prev = 1'b0;
    moved     = 1'b0;
    jumped    = 1'b0;
  endfunction

  // Advance the track by one box; return 1 when the box closes a sequence.
  function automatic bit judge_box(input box_t b, output verdict_t v);
    longint cx2;
    longint cy2;
    longint dx;
    longint dy;
    longint dist64;
    bit     pair;
    cx2  = 2 * longint'(b.left) + longint'(b.width);
    cy2  = 2 * longint'(b.top) + longint'(b.height);
    pair = have_prev;
    if (have_prev) begin
      dx     = cx2 - prev_cx2;
      dy     = cy2 - prev_cy2;
      dist64 = (dx * dx + dy * dy) * 64;
      if (dist64 > longint'(max_bound) * longint'(max_bound)) jumped = 1'b1;
      if (dist64 >= longint'(min_bound) * longint'(min_bound)) moved = 1'b1;
    end
    prev_cx2     = cx2;
    prev_cy2     = cy2;
    have_prev    = 1'b1;
    v.live       = pair && moved && !jumped;
    v.boxes_seen = pair;
    if (!b.last) return 1'b0;
    clear_track();
    return 1'b1;
  endfunction

  function automatic box_t make_box(input int l, input int t, input int w, input int h,
                                    input bit last);
    box_t b;
    b.left   = l[COORD_BITS-1:0];
    b.top    = t[COORD_BITS-1:0];
    b.width  = w[SIZE_BITS-1:0];
    b.height = h[SIZE_BITS-1:0];
    b.last   = last;
    return b;
  endfunction

  function automatic stim_row_t box_row(input int l, input int t, input int w, input int h,
                                        input bit last, input bit typed = 1'b0,
                                        input bit live = 1'b0, input bit seen = 1'b0);
    stim_row_t r;
    r.kind            = ROW_BOX;
    r.idx             = CFG_MIN_SHIFT;
    r.value           = '0;
    r.box             = make_box(l, t, w, h, last);
    r.typed           = typed;
    r.want.live       = live;
    r.want.boxes_seen = seen;
    return r;
  endfunction

  function automatic stim_row_t bound_row(input logic [CFG_IDX_BITS-1:0] idx,
                                          input logic [BOUND_BITS-1:0] value);
    stim_row_t r;
    r                 = box_row(0, 0, 0, 0, 1'b0);
    r.kind            = ROW_BOUND;
    r.idx             = idx;
    r.value           = value;
    return r;
  endfunction

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (tx_calm || r < 60) return 0;
    if (r < 88) return $urandom_range(1, 3);
    if (r < 98) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic int rand_step(input int span);
    int d;
    d = $urandom_range(0, span);
    return ($urandom_range(0, 1) != 0) ? d : -d;
  endfunction

  task automatic flag_mismatch(input string what, input int got, input int want);
    $display("mismatch: %s got %0d expected %0d at %0t", what, got, want, $realtime);
    mismatch_count++;
  endtask

  task automatic send_box(input box_t b, input bit typed, input verdict_t want);
    verdict_t v;
    bit       has_verdict;
    @(negedge clk);
    in_tvalid <= 1'b1;
    in_tdata  <= IN_TDATA_BITS'({b.height, b.width, b.top, b.left});
    in_tlast  <= b.last;
    do @(posedge clk); while (!in_tready);
    has_verdict = judge_box(b, v);
    if (has_verdict) pending_verdicts.push_back(typed ? want : v);
  endtask

  task automatic idle_sender(input int gap);
    if (gap > 0) begin
      @(negedge clk);
      in_tvalid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
  endtask

  task automatic drain_results();
    @(negedge clk);
    in_tvalid <= 1'b0;
    while (pending_verdicts.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_bound(input logic [CFG_IDX_BITS-1:0] idx,
                             input logic [BOUND_BITS-1:0] value);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    @(negedge clk);
    cfg_we    <= 1'b0;
    if (idx == CFG_MIN_SHIFT) min_bound = value;
    else max_bound = value;
  endtask

  always @(negedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else if (rx_calm) begin
      out_tready <= 1'b1;
    end else if (rx_hold > 0) begin
      rx_hold = rx_hold - 1;
      out_tready <= 1'b0;
    end else begin
      rx_roll = $urandom_range(0, 99);
      if (rx_roll < 70) begin
        out_tready <= 1'b1;
      end else begin
        out_tready <= 1'b0;
        rx_hold = (rx_roll < 95) ? $urandom_range(0, 2) : $urandom_range(10, 40);
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      if (pending_verdicts.size() == 0) begin
        flag_mismatch("verdict with none pending", int'(out_tdata), 0);
      end else begin
        head_verdict = pending_verdicts.pop_front();
        if (out_tdata[0] !== head_verdict.live)
          flag_mismatch("live", int'(out_tdata[0]), int'(head_verdict.live));
        if (out_tdata[1] !== head_verdict.boxes_seen)
          flag_mismatch("boxes_seen", int'(out_tdata[1]), int'(head_verdict.boxes_seen));
      end
    end
  end

  initial begin
    stim_row_t rows[$];
    box_t      b;
    verdict_t  none;
    bit        box_busy;
    int        phase;
    int        sent;
    int        seq_len;
    int        span;
    int        k;
    int        cur_l;
    int        cur_t;
    int        cur_w;
    int        cur_h;

    rst_n          = 1'b0;
    in_tvalid      = 1'b0;
    in_tdata       = '0;
    in_tlast       = 1'b0;
    cfg_we         = 1'b0;
    cfg_index      = CFG_MIN_SHIFT;
    cfg_data       = '0;
    min_bound      = MIN_SHIFT_RESET;
    max_bound      = MAX_SHIFT_RESET;
    mismatch_count = 0;
    rx_calm        = 1'b0;
    tx_calm        = 1'b0;
    none.live       = 1'b0;
    none.boxes_seen = 1'b0;
    clear_track();

    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    rows.push_back(box_row(-4096, -4096, 0, 0, 1'b1, 1'b1, 1'b0, 1'b0));
    rows.push_back(box_row(4095, 4095, 4095, 4095, 1'b1, 1'b1, 1'b0, 1'b0));
    rows.push_back(box_row(-4096, -4096, 0, 0, 1'b0));
    rows.push_back(box_row(4095, 4095, 4095, 4095, 1'b1, 1'b1, 1'b0, 1'b1));
    rows.push_back(box_row(100, -100, 20, 30, 1'b0));
    rows.push_back(box_row(100, -100, 20, 30, 1'b1, 1'b1, 1'b0, 1'b1));
    rows.push_back(box_row(0, 0, 10, 10, 1'b0));
    rows.push_back(box_row(10, 0, 10, 10, 1'b1));
    rows.push_back(box_row(0, 0, 8, 8, 1'b0));
    rows.push_back(box_row(1, 1, 8, 8, 1'b0));
    rows.push_back(box_row(300, 0, 8, 8, 1'b1));
    rows.push_back(bound_row(CFG_MIN_SHIFT, 16'd0));
    rows.push_back(bound_row(CFG_MAX_SHIFT, 16'd0));
    rows.push_back(box_row(5, 5, 3, 3, 1'b0));
    rows.push_back(box_row(5, 5, 3, 3, 1'b1));
    rows.push_back(bound_row(CFG_MIN_SHIFT, 16'd2000));
    rows.push_back(bound_row(CFG_MAX_SHIFT, 16'd100));
    rows.push_back(box_row(0, 0, 0, 0, 1'b0));
    rows.push_back(box_row(50, 0, 0, 0, 1'b1));
    rows.push_back(bound_row(CFG_MIN_SHIFT, 16'hFFFF));
    rows.push_back(bound_row(CFG_MAX_SHIFT, 16'hFFFF));
    rows.push_back(box_row(-1, -1, 4095, 4095, 1'b0));
    rows.push_back(box_row(4095, -4096, 0, 4095, 1'b1));
    rows.push_back(bound_row(CFG_MIN_SHIFT, MIN_SHIFT_RESET));
    rows.push_back(bound_row(CFG_MAX_SHIFT, MAX_SHIFT_RESET));

    box_busy = 1'b0;
    foreach (rows[i]) begin
      if (rows[i].kind == ROW_BOUND) begin
        if (box_busy) drain_results();
        box_busy = 1'b0;
        write_bound(rows[i].idx, rows[i].value);
      end else begin
        box_busy = 1'b1;
        send_box(rows[i].box, rows[i].typed, rows[i].want);
        idle_sender(pick_gap());
      end
    end

    for (phase = 0; phase < 6; phase++) begin
      drain_results();
      case (phase)
        0: begin
          write_bound(CFG_MIN_SHIFT, MIN_SHIFT_RESET);
          write_bound(CFG_MAX_SHIFT, MAX_SHIFT_RESET);
        end
        1: begin
          write_bound(CFG_MIN_SHIFT, 16'd0);
          write_bound(CFG_MAX_SHIFT, 16'd0);
        end
        2: begin
          write_bound(CFG_MIN_SHIFT, 16'hFFFF);
          write_bound(CFG_MAX_SHIFT, 16'hFFFF);
        end
        3: begin
          write_bound(CFG_MIN_SHIFT, BOUND_BITS'($urandom_range(1000, 4000)));
          write_bound(CFG_MAX_SHIFT, BOUND_BITS'($urandom_range(0, 900)));
        end
        4: begin
          write_bound(CFG_MIN_SHIFT, BOUND_BITS'($urandom_range(0, 800)));
          write_bound(CFG_MAX_SHIFT, BOUND_BITS'(min_bound + $urandom_range(0, 3000)));
        end
        default: begin
          write_bound(CFG_MIN_SHIFT, BOUND_BITS'($urandom_range(0, 65535)));
          write_bound(CFG_MAX_SHIFT, BOUND_BITS'($urandom_range(0, 65535)));
        end
      endcase
      tx_calm = ($urandom_range(0, 3) == 0);
      rx_calm = ($urandom_range(0, 3) == 0);

      sent = 0;
      while (sent < 250) begin
        if ($urandom_range(0, 99) < 85) begin
          seq_len = ($urandom_range(0, 99) < 10) ? 1 : $urandom_range(2, 7);
          case ($urandom_range(0, 3))
            0: span = 2;
            1: span = int'(min_bound >> 4) + 2;
            2: span = int'(max_bound >> 4) + 2;
            default: span = 8191;
          endcase
          cur_l = $urandom_range(0, 8191) - 4096;
          cur_t = $urandom_range(0, 8191) - 4096;
          cur_w = $urandom_range(0, 4095);
          cur_h = $urandom_range(0, 4095);
          for (k = 0; k < seq_len; k++) begin
            if (k > 0) begin
              cur_l += rand_step(span);
              cur_t += rand_step(span);
              if ($urandom_range(0, 3) == 0) begin
                cur_w += rand_step(8);
                cur_h += rand_step(8);
              end
            end
            b = make_box(cur_l, cur_t, cur_w, cur_h, k == seq_len - 1);
            send_box(b, 1'b0, none);
            sent++;
            idle_sender(pick_gap());
          end
        end else begin
          b = make_box($urandom, $urandom, $urandom, $urandom, $urandom_range(0, 1) != 0);
          send_box(b, 1'b0, none);
          sent++;
          idle_sender(pick_gap());
        end
        // hold the sender until every verdict has been taken
        if ($urandom_range(0, 199) == 0) drain_results();
      end
    end

    drain_results();
    repeat (10) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
